>>> sv/tpq_pkg.sv
// shared types, codes and the ordering function of the task priority queue
package tpq_pkg;

    // request opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // one stored task
    typedef struct packed {
        logic [1:0]  cls;
        logic [31:0] due;
        logic [15:0] minutes;
        logic [31:0] number;
    } t_entry;

    // per-cycle command broadcast along the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_chain_ctl;

    // true when a must leave before b: class, then deadline, then number
    function automatic logic goes_first(input t_entry a, input t_entry b);
        logic [65:0] ka;
        logic [65:0] kb;
        ka = {a.cls, a.due, a.number};
        kb = {b.cls, b.due, b.number};
        return ka < kb;
    endfunction

endpackage

>>> sv/task_priority_queue.sv
// top level of the task priority queue: sorted cell chain, counters and result register
// a request's result is registered, and offered in the cycle after it is accepted
// throughput: one request per cycle while results are taken; every cell compares in parallel
// a new request is taken while a result waits, unless the result side stalls
// reset (synchronous, active low) empties the queue, sets the next task number to one
// and drops any pending result; cell contents are left as they are
module task_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [1:0]  i_prio_class,
    input  logic [31:0] i_due_time,
    input  logic [15:0] i_est_minutes,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_task_number,
    output logic [1:0]  o_out_class,
    output logic [31:0] o_out_due,
    output logic [15:0] o_out_minutes,
    output logic        o_now_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // occupancy and numbering
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      r_next_number;
    logic [31:0]      n_next_number;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_task_number;
    logic [1:0]  r_out_class;
    logic [31:0] r_out_due;
    logic [15:0] r_out_minutes;
    logic        r_now_empty;

    logic [1:0]  n_status;
    logic [31:0] n_task_number;
    logic [1:0]  n_out_class;
    logic [31:0] n_out_due;
    logic [15:0] n_out_minutes;
    logic        n_now_empty;

    logic                accept;
    logic                full;
    logic                empty;
    tpq_pkg::t_chain_ctl ctl;
    tpq_pkg::t_entry     new_entry;

    // chain wiring: cell 0 holds the entry that leaves first
    tpq_pkg::t_entry w_entry     [QUEUE_DEPTH];
    logic            w_new_first [QUEUE_DEPTH];

    // result side frees up at this edge or is already free
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    // errored requests leave the chain untouched
    assign ctl.push = accept && (i_opcode == tpq_pkg::OP_PUSH) && !full;
    assign ctl.pop  = accept && (i_opcode == tpq_pkg::OP_POP) && !empty;

    assign new_entry.cls     = i_prio_class;
    assign new_entry.due     = i_due_time;
    assign new_entry.minutes = i_est_minutes;
    assign new_entry.number  = r_next_number;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic            left_new_first;
        tpq_pkg::t_entry left_entry;
        tpq_pkg::t_entry right_entry;

        if (g == 0) begin : g_head
            // nothing to the left: a displaced head always takes the new entry
            assign left_new_first = 1'b0;
            assign left_entry     = new_entry;
        end else begin : g_mid
            assign left_new_first = w_new_first[g-1];
            assign left_entry     = w_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            // past the tail a pop shifts in an unused slot
            assign right_entry = w_entry[g];
        end else begin : g_body
            assign right_entry = w_entry[g+1];
        end

        tpq_cell u_cell (
            .i_clk            (i_clk),
            .i_ctl            (ctl),
            .i_new            (new_entry),
            .i_occupied       (r_count > CNT_W'(g)),
            .i_left_new_first (left_new_first),
            .i_left_entry     (left_entry),
            .i_right_entry    (right_entry),
            .o_entry          (w_entry[g]),
            .o_new_first      (w_new_first[g])
        );
    end

    // next counters and the result of this request
    always_comb begin
        n_count       = r_count;
        n_next_number = r_next_number;
        n_status      = tpq_pkg::ST_OK;
        n_task_number = '0;
        n_out_class   = '0;
        n_out_due     = '0;
        n_out_minutes = '0;
        if (i_opcode == tpq_pkg::OP_PUSH) begin
            if (full) begin
                n_status = tpq_pkg::ST_FULL;
            end else begin
                n_task_number = r_next_number;
                n_next_number = r_next_number + 32'd1;
                n_count       = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = tpq_pkg::ST_EMPTY;
            end else begin
                // head of the chain is the first in order
                n_task_number = w_entry[0].number;
                n_out_class   = w_entry[0].cls;
                n_out_due     = w_entry[0].due;
                n_out_minutes = w_entry[0].minutes;
                n_count       = r_count - CNT_W'(1);
            end
        end
        n_now_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_next_number <= 32'd1;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_count       <= n_count;
                r_next_number <= n_next_number;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with an accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_task_number <= n_task_number;
            r_out_class   <= n_out_class;
            r_out_due     <= n_out_due;
            r_out_minutes <= n_out_minutes;
            r_now_empty   <= n_now_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_task_number = r_task_number;
    assign o_out_class   = r_out_class;
    assign o_out_due     = r_out_due;
    assign o_out_minutes = r_out_minutes;
    assign o_now_empty   = r_now_empty;

endmodule

>>> sv/tpq_cell.sv
// one cell of the sorted chain: holds one entry, shifts right on insert, left on pop
module tpq_cell (
    input  logic               i_clk,
    input  tpq_pkg::t_chain_ctl i_ctl,
    input  tpq_pkg::t_entry    i_new,
    input  logic               i_occupied,
    input  logic               i_left_new_first,
    input  tpq_pkg::t_entry    i_left_entry,
    input  tpq_pkg::t_entry    i_right_entry,
    output tpq_pkg::t_entry    o_entry,
    output logic               o_new_first
);

    tpq_pkg::t_entry r_entry;
    tpq_pkg::t_entry n_entry;

    // an empty cell orders after everything
    assign o_new_first = !i_occupied || tpq_pkg::goes_first(i_new, r_entry);
    assign o_entry     = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_right_entry;
        end else if (i_ctl.push && o_new_first) begin
            // left neighbour also displaced: take its entry, else the new one lands here
            n_entry = i_left_new_first ? i_left_entry : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> sv/tpq_checker.sv
// port-level assertions for the task priority queue and their bind
module tpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_task_number,
    input logic        o_now_empty
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // every accepted request shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted request gave no result");

    // a pop on empty leaves the queue empty and carries no task number
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == tpq_pkg::ST_EMPTY) |-> o_now_empty && (o_task_number == '0))
        else $error("bad empty pop result");

    // a rejected push means the queue is full, never empty
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == tpq_pkg::ST_FULL) |-> !o_now_empty && (o_task_number == '0))
        else $error("bad full push result");

endmodule

bind task_priority_queue tpq_checker u_tpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_task_number (o_task_number),
    .o_now_empty   (o_now_empty)
);

>>> bench/tb_task_priority_queue.sv
// self-checking testbench for the task priority queue: directed table then random requests
module tb_task_priority_queue;

    import tpq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 200000;
    // result is registered right after acceptance, so a short tail is plenty
    localparam int TAIL_CYCLES  = 10;
    localparam int IDLE_PCT     = 28;

    localparam logic [31:0] DUE_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] MINS_MAX = 16'hFFFF;

    // one result as the queue reports it
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] number;
        logic [1:0]  cls;
        logic [31:0] due;
        logic [15:0] minutes;
        logic        empty;
    } task_result_t;

    // one row of the directed table; typed rows carry their own expectation
    // (the expected data fields of a typed row are all zero: pushes and error cases)
    typedef struct packed {
        logic        op;
        logic [1:0]  cls;
        logic [31:0] due;
        logic [15:0] mins;
        logic        typed;
        logic [1:0]  t_status;
        logic [31:0] t_number;
        logic        t_empty;
    } dir_row_t;

    localparam int DIR_ROWS_N = 25;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // pop straight after reset: empty queue
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b1, ST_EMPTY, 32'd0,  1'b1},
        // fill all sixteen slots, numbers count up from one
        '{OP_PUSH, 2'd1, 32'd1000,   16'd5,    1'b1, ST_OK,    32'd1,  1'b0},
        '{OP_PUSH, 2'd0, DUE_MAX,    MINS_MAX, 1'b1, ST_OK,    32'd2,  1'b0},
        // class three is kept as given and sorts after low
        '{OP_PUSH, 2'd3, 32'd0,      16'd0,    1'b1, ST_OK,    32'd3,  1'b0},
        '{OP_PUSH, 2'd2, 32'd0,      16'd1,    1'b1, ST_OK,    32'd4,  1'b0},
        // equal class and deadline: the older number leaves first
        '{OP_PUSH, 2'd0, 32'd7,      16'd100,  1'b1, ST_OK,    32'd5,  1'b0},
        '{OP_PUSH, 2'd0, 32'd7,      16'd200,  1'b1, ST_OK,    32'd6,  1'b0},
        '{OP_PUSH, 2'd1, 32'd1000,   16'd300,  1'b1, ST_OK,    32'd7,  1'b0},
        '{OP_PUSH, 2'd2, 32'd500,    16'd8,    1'b1, ST_OK,    32'd8,  1'b0},
        '{OP_PUSH, 2'd1, 32'd0,      16'd9,    1'b1, ST_OK,    32'd9,  1'b0},
        '{OP_PUSH, 2'd3, DUE_MAX,    16'd10,   1'b1, ST_OK,    32'd10, 1'b0},
        '{OP_PUSH, 2'd0, 32'd1,      16'd11,   1'b1, ST_OK,    32'd11, 1'b0},
        '{OP_PUSH, 2'd2, 32'd499,    16'd12,   1'b1, ST_OK,    32'd12, 1'b0},
        '{OP_PUSH, 2'd1, 32'd999,    16'd13,   1'b1, ST_OK,    32'd13, 1'b0},
        '{OP_PUSH, 2'd0, DUE_MAX - 1, 16'd14,  1'b1, ST_OK,    32'd14, 1'b0},
        '{OP_PUSH, 2'd3, 32'd0,      16'd15,   1'b1, ST_OK,    32'd15, 1'b0},
        '{OP_PUSH, 2'd1, 32'd1001,   16'd16,   1'b1, ST_OK,    32'd16, 1'b0},
        // push on a full queue: flagged, no number used up
        '{OP_PUSH, 2'd2, 32'd3,      16'd77,   1'b1, ST_FULL,  32'd0,  1'b0},
        // pops and a refill, checked against the predictor
        '{OP_POP,  2'd3, DUE_MAX,    MINS_MAX, 1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_PUSH, 2'd0, 32'd0,      16'd1,    1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b0, ST_OK,    32'd0,  1'b0},
        '{OP_POP,  2'd0, 32'd0,      16'd0,    1'b0, ST_OK,    32'd0,  1'b0}
    };

    // dut ports, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_opcode      = OP_PUSH;
    logic [1:0]  i_prio_class  = '0;
    logic [31:0] i_due_time    = '0;
    logic [15:0] i_est_minutes = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_task_number;
    logic [1:0]  o_out_class;
    logic [31:0] o_out_due;
    logic [15:0] o_out_minutes;
    logic        o_now_empty;

    // shadow copy of the queue contents
    t_entry      pool [QUEUE_DEPTH];
    int          pool_count   = 0;
    logic [31:0] next_task_no = 32'd1;

    task_result_t awaited_answers [$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    // when set, neither side idles
    bit           steady      = 1'b0;

    task_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_prio_class  (i_prio_class),
        .i_due_time    (i_due_time),
        .i_est_minutes (i_est_minutes),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_task_number (o_task_number),
        .o_out_class   (o_out_class),
        .o_out_due     (o_out_due),
        .o_out_minutes (o_out_minutes),
        .o_now_empty   (o_now_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // works out the queue's answer to one request and updates the shadow copy
    function automatic task_result_t queue_answer(input logic op, input logic [1:0] cls,
                                                  input logic [31:0] due,
                                                  input logic [15:0] mins);
        task_result_t r;
        int best;
        r = '0;
        if (op == OP_PUSH) begin
            if (pool_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pool[pool_count].cls     = cls;
                pool[pool_count].due     = due;
                pool[pool_count].minutes = mins;
                pool[pool_count].number  = next_task_no;
                r.number     = next_task_no;
                next_task_no = next_task_no + 32'd1;
                pool_count++;
            end
        end else if (pool_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // class first, then deadline, then the lower number
            best = 0;
            for (int k = 1; k < pool_count; k++) begin
                if (pool[k].cls != pool[best].cls) begin
                    if (pool[k].cls < pool[best].cls) best = k;
                end else if (pool[k].due != pool[best].due) begin
                    if (pool[k].due < pool[best].due) best = k;
                end else if (pool[k].number < pool[best].number) begin
                    best = k;
                end
            end
            r.number  = pool[best].number;
            r.cls     = pool[best].cls;
            r.due     = pool[best].due;
            r.minutes = pool[best].minutes;
            pool_count--;
            // last entry moves into the hole
            pool[best] = pool[pool_count];
        end
        r.empty = (pool_count == 0);
        return r;
    endfunction

    // appends one answer to the awaited list
    function automatic void await_answer(input task_result_t a);
        awaited_answers = {awaited_answers, a};
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // offers one request, with random idle cycles in front, and returns once accepted
    task automatic send_request(input logic op, input logic [1:0] cls,
                                input logic [31:0] due, input logic [15:0] mins);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_prio_class  <= cls;
        i_due_time    <= due;
        i_est_minutes <= mins;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // every taken result is matched against the oldest awaited answer
    always @(posedge i_clk) begin : result_check
        task_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_answers.size() == 0) begin
                $display("%0t: result with no request awaiting it, status %0d number %0h",
                         $time, o_status, o_task_number);
                mismatches++;
            end else begin
                want = awaited_answers.pop_front();
                check_field("status",      want.status,  o_status);
                check_field("task_number", want.number,  o_task_number);
                check_field("out_class",   want.cls,     o_out_class);
                check_field("out_due",     want.due,     o_out_due);
                check_field("out_minutes", want.minutes, o_out_minutes);
                check_field("now_empty",   want.empty,   o_now_empty);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        task_result_t ans;
        task_result_t typed_ans;
        dir_row_t     row;
        int           lean;
        int           push_pct;
        logic         op;
        logic [1:0]   cls;
        logic [31:0]  due;
        logic [15:0]  mins;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < DIR_ROWS_N; n++) begin
            row = DIR_ROWS[n];
            send_request(row.op, row.cls, row.due, row.mins);
            ans = queue_answer(row.op, row.cls, row.due, row.mins);
            if (row.typed) begin
                typed_ans        = '0;
                typed_ans.status = row.t_status;
                typed_ans.number = row.t_number;
                typed_ans.empty  = row.t_empty;
                await_answer(typed_ans);
            end else begin
                await_answer(ans);
            end
        end

        // random part: phases lean towards filling, draining or a mix,
        // so the queue swings between full and empty
        lean = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) lean = $urandom_range(0, 2);
            steady = (n >= 150 && n < 300);
            if (n == 500) begin
                // hold off until every awaited result is in
                i_in_valid <= 1'b0;
                while (awaited_answers.size() != 0) @(posedge i_clk);
            end
            case (lean)
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            cls = 2'($urandom_range(0, 3));
            // narrow deadlines give plenty of ties, so numbers decide
            case ($urandom_range(0, 9))
                0:       due = 32'd0;
                1:       due = DUE_MAX;
                2, 3, 4: due = $urandom_range(0, 15);
                default: due = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       mins = 16'd0;
                1:       mins = MINS_MAX;
                default: mins = 16'($urandom);
            endcase
            send_request(op, cls, due, mins);
            await_answer(queue_answer(op, cls, due, mins));
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
